// File: rtl/ptt_pkg.sv
// Package for the proximity trigger table: shared codes, state type and the scan tag.
// No dependencies; ptt_dist_pipe and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package ptt_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_ACT     = 2'd1;
  localparam logic [1:0] KIND_NEAREST = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOMATCH = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  // Width of the reported entry id.
  localparam int ID_W = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Control that travels alongside each entry read through the distance pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } scan_tag_t;

endpackage

// File: rtl/ptt_entry_mem.sv
// Entry memory of the proximity trigger table: one write port, one registered read port.
// Depends on nothing but the clock; the entry layout is set by the top level.
`timescale 1ns / 1ps

module ptt_entry_mem #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 80,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ptt_dist_pipe.sv
// Three-stage squared-distance pipeline: entry word in, squared distance and hit flag out.
// Depends on ptt_pkg for the scan tag type.
`timescale 1ns / 1ps

module ptt_dist_pipe #(
  parameter int COORD_W = 20,
  parameter int IDX_W   = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ptt_pkg::scan_tag_t         in_tag,
  input  logic [IDX_W-1:0]           in_idx,
  input  logic [4*COORD_W-1:0]       in_entry,
  input  logic signed [COORD_W-1:0]  pos_x,
  input  logic signed [COORD_W-1:0]  pos_y,
  input  logic signed [COORD_W-1:0]  pos_z,
  output ptt_pkg::scan_tag_t         res_tag,
  output logic [IDX_W-1:0]           res_idx,
  output logic [4*COORD_W-1:0]       res_entry,
  output logic [2*COORD_W+3:0]       res_d2,
  output logic                       res_hit
);

  localparam int W  = COORD_W;
  localparam int RW = COORD_W - 1;
  localparam int EW = 4 * COORD_W;
  localparam int DW = 2 * COORD_W + 4;

  // Stage A: absolute coordinate differences.
  ptt_pkg::scan_tag_t tag_a_r;
  logic [IDX_W-1:0]   idx_a_r;
  logic [EW-1:0]      entry_a_r;
  logic [W:0]         mag_x_a_r, mag_y_a_r, mag_z_a_r;
  // Stage B: squares.
  ptt_pkg::scan_tag_t tag_b_r;
  logic [IDX_W-1:0]   idx_b_r;
  logic [EW-1:0]      entry_b_r;
  logic [2*W+1:0]     sq_x_b_r, sq_y_b_r, sq_z_b_r;
  logic [2*RW-1:0]    rsq_b_r;
  // Stage C: sum and compare.
  ptt_pkg::scan_tag_t tag_c_r;
  logic [IDX_W-1:0]   idx_c_r;
  logic [EW-1:0]      entry_c_r;
  logic [DW-1:0]      d2_c_r;
  logic               hit_c_r;

  logic signed [W:0] dx, dy, dz;
  logic [W:0]        mag_x, mag_y, mag_z;
  logic [DW-1:0]     d2_sum;

  always_comb begin
    dx = {pos_x[W-1], pos_x} - {in_entry[W-1], in_entry[W-1:0]};
    dy = {pos_y[W-1], pos_y} - {in_entry[2*W-1], in_entry[2*W-1:W]};
    dz = {pos_z[W-1], pos_z} - {in_entry[3*W-1], in_entry[3*W-1:2*W]};
    mag_x = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
    mag_y = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
    mag_z = dz[W] ? (W+1)'(-dz) : (W+1)'(dz);
    d2_sum = DW'(sq_x_b_r) + DW'(sq_y_b_r) + DW'(sq_z_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      tag_c_r <= '0;
    end else begin
      tag_a_r <= in_tag;
      tag_b_r <= tag_a_r;
      tag_c_r <= tag_b_r;
    end
  end

  always_ff @(posedge clk) begin
    idx_a_r   <= in_idx;
    entry_a_r <= in_entry;
    mag_x_a_r <= mag_x;
    mag_y_a_r <= mag_y;
    mag_z_a_r <= mag_z;

    idx_b_r   <= idx_a_r;
    entry_b_r <= entry_a_r;
    sq_x_b_r  <= mag_x_a_r * mag_x_a_r;
    sq_y_b_r  <= mag_y_a_r * mag_y_a_r;
    sq_z_b_r  <= mag_z_a_r * mag_z_a_r;
    rsq_b_r   <= entry_a_r[3*W+RW-1:3*W] * entry_a_r[3*W+RW-1:3*W];

    idx_c_r   <= idx_b_r;
    entry_c_r <= entry_b_r;
    d2_c_r    <= d2_sum;
    hit_c_r   <= (d2_sum <= DW'(rsq_b_r));
  end

  assign res_tag   = tag_c_r;
  assign res_idx   = idx_c_r;
  assign res_entry = entry_c_r;
  assign res_d2    = d2_c_r;
  assign res_hit   = hit_c_r;

endmodule

// File: rtl/proximity_trigger_table_unit.sv
// Top level of the proximity trigger table: command interface, sequencer and result register.
// Depends on ptt_pkg, ptt_entry_mem and ptt_dist_pipe.
`timescale 1ns / 1ps

// The block holds up to MAX_ENTRIES trigger spheres in a single-port-read entry memory and
// takes one transaction at a time: a transaction is accepted at a rising edge where start
// is high and busy is low, and exactly one result follows, shown on the out_ ports for one
// cycle with out_valid high. The receiver cannot stall, so the result must be captured in
// that cycle. Add and clear transactions finish at once: busy never rises and the result
// appears in the cycle after acceptance, so they may be issued on every cycle. Activation
// and nearest transactions read the stored entries one per cycle from the memory and run
// each through a three-stage squared-distance pipeline; busy stays high until the result
// appears, and on an empty table the scan is skipped. There is no clearing pass after
// reset: entries are only ever read below the fill count, so stale contents are never
// seen. A clear transaction simply zeroes the fill count.
module proximity_trigger_table_unit #(
  parameter int MAX_ENTRIES = 256,
  parameter int COORD_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic [COORD_WIDTH-2:0]        in_radius_in,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [ptt_pkg::ID_W-1:0]      out_entry_id,
  output logic signed [COORD_WIDTH-1:0] out_entry_x,
  output logic signed [COORD_WIDTH-1:0] out_entry_y,
  output logic signed [COORD_WIDTH-1:0] out_entry_z,
  output logic [COORD_WIDTH-2:0]        out_entry_radius,
  output logic                          out_entry_fired
);

  localparam int W     = COORD_WIDTH;
  localparam int RW    = COORD_WIDTH - 1;
  localparam int EW    = 4 * COORD_WIDTH;
  localparam int DW    = 2 * COORD_WIDTH + 4;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int FIRED_BIT = EW - 1;

  // State and latched transaction.
  ptt_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic signed [W-1:0] pos_x_r, pos_x_nxt;
  logic signed [W-1:0] pos_y_r, pos_y_nxt;
  logic signed [W-1:0] pos_z_r, pos_z_nxt;

  // Running best candidate of a scan.
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [EW-1:0]    best_entry_r, best_entry_nxt;
  logic [DW-1:0]    best_d_r, best_d_nxt;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [ptt_pkg::ID_W-1:0] out_id_r, out_id_nxt;
  logic [W-1:0]     out_x_r, out_x_nxt;
  logic [W-1:0]     out_y_r, out_y_nxt;
  logic [W-1:0]     out_z_r, out_z_nxt;
  logic [RW-1:0]    out_radius_r, out_radius_nxt;
  logic             out_fired_r, out_fired_nxt;

  // Memory and pipeline hookup.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [EW-1:0]    mem_wdata;
  logic [EW-1:0]    mem_rdata;
  ptt_pkg::scan_tag_t rd_tag, rd_tag_r;
  logic [IDX_W-1:0]   rd_idx_r;
  ptt_pkg::scan_tag_t res_tag;
  logic [IDX_W-1:0]   res_idx;
  logic [EW-1:0]      res_entry;
  logic [DW-1:0]      res_d2;
  logic               res_hit;

  logic accept;
  logic scan_last;
  logic table_full;
  logic [CNT_W-1:0] add_id_full;
  logic [CNT_W-1:0] best_id_full;

  assign busy       = (state_r != ptt_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign scan_last  = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);
  assign table_full = (count_r >= CNT_W'(MAX_ENTRIES));
  assign add_id_full  = count_r + CNT_W'(1);
  assign best_id_full = CNT_W'(best_idx_r) + CNT_W'(1);

  ptt_entry_mem #(
    .DEPTH  (MAX_ENTRIES),
    .WIDTH  (EW),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (scan_idx_r),
    .rdata (mem_rdata)
  );

  ptt_dist_pipe #(
    .COORD_W (W),
    .IDX_W   (IDX_W)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tag    (rd_tag_r),
    .in_idx    (rd_idx_r),
    .in_entry  (mem_rdata),
    .pos_x     (pos_x_r),
    .pos_y     (pos_y_r),
    .pos_z     (pos_z_r),
    .res_tag   (res_tag),
    .res_idx   (res_idx),
    .res_entry (res_entry),
    .res_d2    (res_d2),
    .res_hit   (res_hit)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptt_pkg::ST_IDLE: begin
        if (accept && (in_kind == ptt_pkg::KIND_ACT || in_kind == ptt_pkg::KIND_NEAREST)) begin
          state_nxt = (count_r == '0) ? ptt_pkg::ST_FINISH : ptt_pkg::ST_SCAN;
        end
      end
      ptt_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ptt_pkg::ST_DRAIN;
        end
      end
      ptt_pkg::ST_DRAIN: begin
        if (res_tag.valid && res_tag.last) begin
          state_nxt = ptt_pkg::ST_FINISH;
        end
      end
      ptt_pkg::ST_FINISH: begin
        state_nxt = ptt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ptt_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and output logic of the sequencer.
  always_comb begin
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    kind_nxt       = kind_r;
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    pos_z_nxt      = pos_z_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_entry_nxt = best_entry_r;
    best_d_nxt     = best_d_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_z_nxt      = out_z_r;
    out_radius_nxt = out_radius_r;
    out_fired_nxt  = out_fired_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[IDX_W-1:0];
    mem_wdata      = {1'b0, in_radius_in, in_pos_z, in_pos_y, in_pos_x};
    rd_tag         = '0;

    // Pipeline results are folded into the running best while a scan runs and drains.
    if (res_tag.valid) begin
      if (kind_r == ptt_pkg::KIND_ACT) begin
        if (!found_r && res_hit && !res_entry[FIRED_BIT]) begin
          found_nxt      = 1'b1;
          best_idx_nxt   = res_idx;
          best_entry_nxt = res_entry;
        end
      end else begin
        if (!found_r || (res_d2 < best_d_r)) begin
          found_nxt      = 1'b1;
          best_idx_nxt   = res_idx;
          best_entry_nxt = res_entry;
          best_d_nxt     = res_d2;
        end
      end
    end

    unique case (state_r)
      ptt_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt     = in_kind;
          pos_x_nxt    = in_pos_x;
          pos_y_nxt    = in_pos_y;
          pos_z_nxt    = in_pos_z;
          found_nxt    = 1'b0;
          scan_idx_nxt = '0;
          case (in_kind)
            ptt_pkg::KIND_ADD: begin
              out_valid_nxt = 1'b1;
              if (table_full) begin
                out_status_nxt = ptt_pkg::STATUS_FULL;
                out_id_nxt     = '0;
                out_x_nxt      = '0;
                out_y_nxt      = '0;
                out_z_nxt      = '0;
                out_radius_nxt = '0;
                out_fired_nxt  = 1'b0;
              end else begin
                mem_we         = 1'b1;
                count_nxt      = add_id_full;
                out_status_nxt = ptt_pkg::STATUS_OK;
                out_id_nxt     = ptt_pkg::ID_W'(add_id_full);
                out_x_nxt      = in_pos_x;
                out_y_nxt      = in_pos_y;
                out_z_nxt      = in_pos_z;
                out_radius_nxt = in_radius_in;
                out_fired_nxt  = 1'b0;
              end
            end
            ptt_pkg::KIND_CLEAR: begin
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ptt_pkg::STATUS_OK;
              out_id_nxt     = '0;
              out_x_nxt      = '0;
              out_y_nxt      = '0;
              out_z_nxt      = '0;
              out_radius_nxt = '0;
              out_fired_nxt  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ptt_pkg::ST_SCAN: begin
        rd_tag.valid = 1'b1;
        rd_tag.last  = scan_last;
        scan_idx_nxt = scan_idx_r + IDX_W'(1);
      end
      ptt_pkg::ST_DRAIN: begin
      end
      ptt_pkg::ST_FINISH: begin
        out_valid_nxt = 1'b1;
        if (found_r) begin
          out_status_nxt = ptt_pkg::STATUS_OK;
          out_id_nxt     = ptt_pkg::ID_W'(best_id_full);
          out_x_nxt      = best_entry_r[W-1:0];
          out_y_nxt      = best_entry_r[2*W-1:W];
          out_z_nxt      = best_entry_r[3*W-1:2*W];
          out_radius_nxt = best_entry_r[3*W+RW-1:3*W];
          if (kind_r == ptt_pkg::KIND_ACT) begin
            // Write the winning entry back with its fired mark set.
            out_fired_nxt = 1'b1;
            mem_we        = 1'b1;
            mem_waddr     = best_idx_r;
            mem_wdata     = {1'b1, best_entry_r[EW-2:0]};
          end else begin
            out_fired_nxt = best_entry_r[FIRED_BIT];
          end
        end else begin
          out_status_nxt = ptt_pkg::STATUS_NOMATCH;
          out_id_nxt     = '0;
          out_x_nxt      = '0;
          out_y_nxt      = '0;
          out_z_nxt      = '0;
          out_radius_nxt = '0;
          out_fired_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rd_tag_r    <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rd_tag_r    <= rd_tag;
      found_r     <= found_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    rd_idx_r     <= scan_idx_r;
    kind_r       <= kind_nxt;
    pos_x_r      <= pos_x_nxt;
    pos_y_r      <= pos_y_nxt;
    pos_z_r      <= pos_z_nxt;
    best_idx_r   <= best_idx_nxt;
    best_entry_r <= best_entry_nxt;
    best_d_r     <= best_d_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_z_r      <= out_z_nxt;
    out_radius_r <= out_radius_nxt;
    out_fired_r  <= out_fired_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_id     = out_id_r;
  assign out_entry_x      = out_x_r;
  assign out_entry_y      = out_y_r;
  assign out_entry_z      = out_z_r;
  assign out_entry_radius = out_radius_r;
  assign out_entry_fired  = out_fired_r;

`ifndef SYNTH
  // The fill count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("fill count beyond table depth");

  // A scan is only ever started on a non-empty table.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptt_pkg::ST_SCAN) |-> (count_r != '0))
    else $error("scan running on an empty table");

  // An accepted clear leaves the table empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == ptt_pkg::KIND_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty the table");

  // Every finished scan produces a result in the next cycle.
  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptt_pkg::ST_FINISH) |=> out_valid)
    else $error("scan finished without a result");

  // A full-table result carries no entry id.
  a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ptt_pkg::STATUS_FULL) |-> (out_entry_id == '0))
    else $error("full status with an entry id");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the proximity trigger table: directed table, then random episodes.
// Depends on rtl/ptt_pkg.sv and the RTL below proximity_trigger_table_unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_ENTRIES  = 256;
  localparam int COORD_W      = 20;
  localparam int RAD_W        = COORD_W - 1;
  localparam int N_DIR        = 23;
  localparam int RANDOM_ITEMS = 1600;
  // The slowest legal transaction is a scan of a full table, and the sender may also pause
  // between transactions; the limit allows for both over the whole run.
  localparam int CYCLE_LIMIT  = 2500000;
  // Enough quiet cycles after the last result to catch a stray one from a full-table scan.
  localparam int SETTLE       = 300;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RAD_W-1:0]          radius_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [ptt_pkg::ID_W-1:0] id;
    coord_t                   x;
    coord_t                   y;
    coord_t                   z;
    radius_t                  radius;
    logic                     fired;
  } report_t;

  typedef struct {
    logic [1:0] kind;
    coord_t     x;
    coord_t     y;
    coord_t     z;
    radius_t    r;
    bit         typed;
    report_t    want;
  } dir_row_t;

  localparam coord_t  C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t  C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t  C_NEG = {COORD_W{1'b1}};
  localparam radius_t R_MAX = {RAD_W{1'b1}};

  localparam report_t NO_MATCH = '{ptt_pkg::STATUS_NOMATCH, '0, '0, '0, '0, '0, 1'b0};
  localparam report_t ALL_DONE = '{ptt_pkg::STATUS_OK, '0, '0, '0, '0, '0, 1'b0};

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = ptt_pkg::KIND_ADD;
  coord_t  in_pos_x = '0;
  coord_t  in_pos_y = '0;
  coord_t  in_pos_z = '0;
  radius_t in_radius_in = '0;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic [ptt_pkg::ID_W-1:0] out_entry_id;
  coord_t                   out_entry_x;
  coord_t                   out_entry_y;
  coord_t                   out_entry_z;
  radius_t                  out_entry_radius;
  logic                     out_entry_fired;

  proximity_trigger_table_unit #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .COORD_WIDTH(COORD_W)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_radius_in    (in_radius_in),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_id    (out_entry_id),
    .out_entry_x     (out_entry_x),
    .out_entry_y     (out_entry_y),
    .out_entry_z     (out_entry_z),
    .out_entry_radius(out_entry_radius),
    .out_entry_fired (out_entry_fired)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The testbench's own copy of the trigger table. Entries at and above fill_count are never
  // read, so the stores need no clearing.
  coord_t  cen_x [MAX_ENTRIES];
  coord_t  cen_y [MAX_ENTRIES];
  coord_t  cen_z [MAX_ENTRIES];
  radius_t rad_store [MAX_ENTRIES];
  bit      fired_mark [MAX_ENTRIES];
  int      fill_count = 0;

  // Results predicted for accepted transactions, oldest first.
  report_t awaited_reports[$];

  dir_row_t dir_rows [N_DIR];
  int mismatches = 0;
  int issued = 0;
  int cycles = 0;
  int burst_left = 0;

  // Exact squared distance from a position to a stored centre. Each difference needs at most
  // 21 bits, so the sum of three squares fits comfortably in 64 bits.
  function automatic longint sq_dist(input int idx, input coord_t px, input coord_t py,
                                     input coord_t pz);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'(px) - longint'(cen_x[idx]);
    dy = longint'(py) - longint'(cen_y[idx]);
    dz = longint'(pz) - longint'(cen_z[idx]);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic report_t entry_report(input int idx);
    report_t res;
    res.status = ptt_pkg::STATUS_OK;
    res.id     = ptt_pkg::ID_W'(idx + 1);
    res.x      = cen_x[idx];
    res.y      = cen_y[idx];
    res.z      = cen_z[idx];
    res.radius = rad_store[idx];
    res.fired  = fired_mark[idx];
    return res;
  endfunction

  // Applies one transaction to the local table and returns the result it should produce.
  function automatic report_t table_response(input logic [1:0] kind, input coord_t px,
                                             input coord_t py, input coord_t pz,
                                             input radius_t pr);
    report_t res;
    longint  d;
    longint  best_d;
    int      best;
    bit      found;
    res = ALL_DONE;
    case (kind)
      ptt_pkg::KIND_ADD: begin
        if (fill_count >= MAX_ENTRIES) begin
          res.status = ptt_pkg::STATUS_FULL;
        end else begin
          cen_x[fill_count] = px;
          cen_y[fill_count] = py;
          cen_z[fill_count] = pz;
          rad_store[fill_count] = pr;
          fired_mark[fill_count] = 1'b0;
          res = entry_report(fill_count);
          fill_count++;
        end
      end
      ptt_pkg::KIND_ACT: begin
        // First armed entry whose sphere holds the position; the boundary counts as inside.
        res = NO_MATCH;
        for (int i = 0; i < fill_count; i++) begin
          if (!fired_mark[i] &&
              sq_dist(i, px, py, pz) <= longint'(rad_store[i]) * longint'(rad_store[i])) begin
            fired_mark[i] = 1'b1;
            res = entry_report(i);
            break;
          end
        end
      end
      ptt_pkg::KIND_NEAREST: begin
        // Fired entries take part; a strict compare keeps the earliest entry on a tie.
        found = 1'b0;
        best = 0;
        best_d = 0;
        for (int i = 0; i < fill_count; i++) begin
          d = sq_dist(i, px, py, pz);
          if (!found || d < best_d) begin
            found = 1'b1;
            best = i;
            best_d = d;
          end
        end
        res = found ? entry_report(best) : NO_MATCH;
      end
      default: begin
        fill_count = 0;
      end
    endcase
    return res;
  endfunction

  function automatic coord_t pick_coord();
    coord_t v;
    case ($urandom_range(0, 5))
      0: v = C_MAX;
      1: v = C_MIN;
      2: v = COORD_W'($urandom_range(0, 255)) - COORD_W'(128);
      default: v = COORD_W'($urandom());
    endcase
    return v;
  endfunction

  function automatic radius_t pick_radius();
    radius_t v;
    case ($urandom_range(0, 5))
      0: v = R_MAX;
      1: v = '0;
      2, 3: v = RAD_W'($urandom_range(0, 512));
      default: v = RAD_W'($urandom());
    endcase
    return v;
  endfunction

  // A position close to, or exactly on, a stored centre, so that activations actually hit.
  task automatic aim_near(output coord_t px, output coord_t py, output coord_t pz);
    int idx;
    bit exact;
    if (fill_count == 0) begin
      px = pick_coord();
      py = pick_coord();
      pz = pick_coord();
    end else begin
      idx = $urandom_range(0, fill_count - 1);
      exact = ($urandom_range(0, 3) == 0);
      px = cen_x[idx] + (exact ? '0 : COORD_W'($urandom_range(0, 64)) - COORD_W'(32));
      py = cen_y[idx] + (exact ? '0 : COORD_W'($urandom_range(0, 64)) - COORD_W'(32));
      pz = cen_z[idx] + (exact ? '0 : COORD_W'($urandom_range(0, 64)) - COORD_W'(32));
    end
  endtask

  // The sender works in bursts. Between bursts start drops for a random gap, now and then a
  // long one, so that the next transaction arrives at every phase of a scan in progress.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(10, 80)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Presents one transaction and holds it until the block takes it. Busy is read as it stood
  // before the edge, so the acceptance test matches the block's own. The expected result is
  // queued at the accepting edge, before the block can show it.
  task automatic issue(input logic [1:0] kind, input coord_t px, input coord_t py,
                       input coord_t pz, input radius_t pr, input bit typed,
                       input report_t want);
    report_t predicted;
    in_kind <= kind;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_radius_in <= pr;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = table_response(kind, px, py, pz, pr);
    awaited_reports.push_back(typed ? want : predicted);
    issued++;
    pace();
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  task automatic compare_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      flag_mismatch(what, got, want);
    end
  endtask

  // Results cannot be held off, so every strobe is taken at the edge that ends its cycle and
  // compared with the oldest expectation.
  always @(posedge clk) begin : watch_results
    report_t want;
    if (rst_n && out_valid) begin
      if (awaited_reports.size() == 0) begin
        flag_mismatch("result with no transaction outstanding, status", 64'(out_status), '0);
      end else begin
        want = awaited_reports.pop_front();
        compare_field("status", 64'(out_status), 64'(want.status));
        compare_field("entry_id", 64'(out_entry_id), 64'(want.id));
        compare_field("entry_x", 64'(out_entry_x), 64'(want.x));
        compare_field("entry_y", 64'(out_entry_y), 64'(want.y));
        compare_field("entry_z", 64'(out_entry_z), 64'(want.z));
        compare_field("entry_radius", 64'(out_entry_radius), 64'(want.radius));
        compare_field("entry_fired", 64'(out_entry_fired), 64'(want.fired));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    coord_t px;
    coord_t py;
    coord_t pz;
    int     episode;
    int     pick;
    int     idx;

    // Directed rows. Expected results are written out only where they are obvious: empty
    // table, adds, clears. The rest is left to the predictor, with the case noted alongside.
    dir_rows[0]  = '{ptt_pkg::KIND_NEAREST, '0, '0, '0, '0, 1'b1, NO_MATCH};
    dir_rows[1]  = '{ptt_pkg::KIND_ACT, C_MAX, C_MAX, C_MAX, R_MAX, 1'b1, NO_MATCH};
    dir_rows[2]  = '{ptt_pkg::KIND_ADD, C_MAX, C_MIN, '0, R_MAX, 1'b1,
                     '{ptt_pkg::STATUS_OK, 9'd1, C_MAX, C_MIN, '0, R_MAX, 1'b0}};
    dir_rows[3]  = '{ptt_pkg::KIND_ADD, C_MIN, C_MAX, C_NEG, '0, 1'b1,
                     '{ptt_pkg::STATUS_OK, 9'd2, C_MIN, C_MAX, C_NEG, '0, 1'b0}};
    dir_rows[4]  = '{ptt_pkg::KIND_ADD, '0, '0, '0, 19'd16, 1'b1,
                     '{ptt_pkg::STATUS_OK, 9'd3, '0, '0, '0, 19'd16, 1'b0}};
    // Only the third entry reaches the origin; the first two are far off or have zero radius.
    dir_rows[5]  = '{ptt_pkg::KIND_ACT, '0, '0, '0, '0, 1'b0, '0};
    // The same position again finds that entry already fired.
    dir_rows[6]  = '{ptt_pkg::KIND_ACT, '0, '0, '0, '0, 1'b0, '0};
    // A fired entry still wins a nearest search.
    dir_rows[7]  = '{ptt_pkg::KIND_NEAREST, '0, '0, '0, '0, 1'b0, '0};
    dir_rows[8]  = '{ptt_pkg::KIND_ADD, 20'sd16, '0, '0, 19'd16, 1'b1,
                     '{ptt_pkg::STATUS_OK, 9'd4, 20'sd16, '0, '0, 19'd16, 1'b0}};
    // Distance exactly equal to the radius counts as inside.
    dir_rows[9]  = '{ptt_pkg::KIND_ACT, '0, '0, '0, '0, 1'b0, '0};
    dir_rows[10] = '{ptt_pkg::KIND_ADD, '0, '0, '0, '0, 1'b1,
                     '{ptt_pkg::STATUS_OK, 9'd5, '0, '0, '0, '0, 1'b0}};
    // Two entries at distance zero: the earlier one is reported.
    dir_rows[11] = '{ptt_pkg::KIND_NEAREST, '0, '0, '0, R_MAX, 1'b0, '0};
    // A zero-radius entry fires only on an exact hit.
    dir_rows[12] = '{ptt_pkg::KIND_ACT, C_MIN, C_MAX, C_NEG, '0, 1'b0, '0};
    dir_rows[13] = '{ptt_pkg::KIND_NEAREST, C_MIN, C_MIN, C_MIN, '0, 1'b0, '0};
    dir_rows[14] = '{ptt_pkg::KIND_ACT, C_MIN, C_MIN, C_MIN, R_MAX, 1'b0, '0};
    dir_rows[15] = '{ptt_pkg::KIND_ADD, C_NEG, C_NEG, C_NEG, R_MAX, 1'b1,
                     '{ptt_pkg::STATUS_OK, 9'd6, C_NEG, C_NEG, C_NEG, R_MAX, 1'b0}};
    dir_rows[16] = '{ptt_pkg::KIND_ACT, C_MAX, C_MAX, C_MAX, '0, 1'b0, '0};
    dir_rows[17] = '{ptt_pkg::KIND_ACT, 20'sd1, 20'sd2, 20'sd3, '0, 1'b0, '0};
    dir_rows[18] = '{ptt_pkg::KIND_CLEAR, C_MAX, C_MIN, C_NEG, R_MAX, 1'b1, ALL_DONE};
    dir_rows[19] = '{ptt_pkg::KIND_NEAREST, '0, '0, '0, '0, 1'b1, NO_MATCH};
    dir_rows[20] = '{ptt_pkg::KIND_ACT, '0, '0, '0, '0, 1'b1, NO_MATCH};
    // Ids start again from one after a clear.
    dir_rows[21] = '{ptt_pkg::KIND_ADD, 20'sd5, 20'sd6, 20'sd7, 19'd8, 1'b1,
                     '{ptt_pkg::STATUS_OK, 9'd1, 20'sd5, 20'sd6, 20'sd7, 19'd8, 1'b0}};
    dir_rows[22] = '{ptt_pkg::KIND_CLEAR, '0, '0, '0, '0, 1'b1, ALL_DONE};

    // Synchronous reset, released once and never asserted again.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      issue(dir_rows[i].kind, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].r,
            dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part, built from episodes. Most episodes fill a small table and then query it
    // near its entries; two of them fill the table completely and push further adds
    // against the full table before scanning it end to end.
    episode = 0;
    while (issued < N_DIR + RANDOM_ITEMS) begin
      if (episode == 8 || episode == 40) begin
        issue(ptt_pkg::KIND_CLEAR, pick_coord(), pick_coord(), pick_coord(), pick_radius(),
              1'b0, '0);
        while (fill_count < MAX_ENTRIES) begin
          issue(ptt_pkg::KIND_ADD, pick_coord(), pick_coord(), pick_coord(), pick_radius(),
                1'b0, '0);
        end
        repeat ($urandom_range(1, 3)) begin
          issue(ptt_pkg::KIND_ADD, pick_coord(), pick_coord(), pick_coord(), pick_radius(),
                1'b0, '0);
        end
        repeat (4) begin
          aim_near(px, py, pz);
          issue(ptt_pkg::KIND_ACT, px, py, pz, pick_radius(), 1'b0, '0);
        end
        repeat (2) begin
          aim_near(px, py, pz);
          issue(ptt_pkg::KIND_NEAREST, px, py, pz, pick_radius(), 1'b0, '0);
        end
      end else begin
        // Keep scans short: a large table left over from earlier is always cleared.
        if (fill_count > 32 || $urandom_range(0, 2) == 0) begin
          issue(ptt_pkg::KIND_CLEAR, pick_coord(), pick_coord(), pick_coord(), pick_radius(),
                1'b0, '0);
        end
        repeat ($urandom_range(1, 12)) begin
          if (fill_count > 0 && $urandom_range(0, 3) == 0) begin
            // A repeated centre sets up ties for the nearest search.
            idx = $urandom_range(0, fill_count - 1);
            issue(ptt_pkg::KIND_ADD, cen_x[idx], cen_y[idx], cen_z[idx], pick_radius(),
                  1'b0, '0);
          end else begin
            issue(ptt_pkg::KIND_ADD, pick_coord(), pick_coord(), pick_coord(), pick_radius(),
                  1'b0, '0);
          end
        end
        repeat ($urandom_range(4, 16)) begin
          pick = $urandom_range(0, 99);
          aim_near(px, py, pz);
          if (pick < 40) begin
            issue(ptt_pkg::KIND_ACT, px, py, pz, pick_radius(), 1'b0, '0);
          end else if (pick < 65) begin
            issue(ptt_pkg::KIND_NEAREST, px, py, pz, pick_radius(), 1'b0, '0);
          end else if (pick < 80) begin
            issue(ptt_pkg::KIND_ADD, pick_coord(), pick_coord(), pick_coord(), pick_radius(),
                  1'b0, '0);
          end else if (pick < 92) begin
            issue(ptt_pkg::KIND_ACT, pick_coord(), pick_coord(), pick_coord(), pick_radius(),
                  1'b0, '0);
          end else if (pick < 96) begin
            issue(ptt_pkg::KIND_CLEAR, pick_coord(), pick_coord(), pick_coord(),
                  pick_radius(), 1'b0, '0);
          end else begin
            issue(ptt_pkg::KIND_NEAREST, pick_coord(), pick_coord(), pick_coord(),
                  pick_radius(), 1'b0, '0);
          end
        end
      end
      episode++;
    end

    // Drain: wait for every outstanding result, then stay a while longer in case the block
    // produces one it should not.
    start <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
